>>> hdl/utf8_validating_char_counter_core_macros.svh
// Assertion helpers for the checker file of this block.
// Each macro expands to one labeled concurrent assertion that is
// disabled while the asynchronous reset is asserted.
`ifndef UTF8_VALIDATING_CHAR_COUNTER_CORE_MACROS_SVH
`define UTF8_VALIDATING_CHAR_COUNTER_CORE_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define UTF8VC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8vc checker: same-cycle property failed");

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define UTF8VC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8vc checker: next-cycle property failed");

`endif

>>> hdl/utf8vc_pkg.sv
`timescale 1ns / 1ps

package utf8vc_pkg;

    // Default saturation limit for every counter and offset.
    localparam longint unsigned MAX_BYTES_DEFAULT = 64'd65535;

    // Width of the counters and offsets carried on the result word.
    localparam int unsigned COUNT_W = 16;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PARTIAL_ON_ERROR   = 2'd0;
    localparam logic [1:0] CFG_STOP_AT_NUL        = 2'd1;
    localparam logic [1:0] CFG_EXTENDED_SEQUENCES = 2'd2;

    // Byte prefix masks and patterns.
    localparam logic [7:0] MASK_80 = 8'h80;
    localparam logic [7:0] MASK_C0 = 8'hc0;
    localparam logic [7:0] MASK_E0 = 8'he0;
    localparam logic [7:0] MASK_F0 = 8'hf0;
    localparam logic [7:0] MASK_F8 = 8'hf8;
    localparam logic [7:0] MASK_FC = 8'hfc;
    localparam logic [7:0] MASK_FE = 8'hfe;

    // Classification of one byte, handed from the decoder to the scanner.
    typedef struct packed {
        logic       is_nul;
        logic       is_ascii;
        logic       is_cont;
        logic [2:0] need;
    } lead_info_t;

endpackage

>>> hdl/utf8vc_lead_decode.sv
`timescale 1ns / 1ps

module utf8vc_lead_decode
(
    input  logic [7:0]              data_byte,
    input  logic                    extended_sequences,
    output utf8vc_pkg::lead_info_t  info
);
    import utf8vc_pkg::*;

    // The number of continuation bytes a lead asks for; zero marks a byte
    // that cannot start a multi-byte sequence in the current mode.
    always_comb
    begin
        info.is_nul   = (data_byte == 8'h00);
        info.is_ascii = ((data_byte & MASK_80) == 8'h00);
        info.is_cont  = ((data_byte & MASK_C0) == MASK_80);
        if (extended_sequences && ((data_byte & MASK_FE) == MASK_FC))
        begin
            info.need = 3'd5;
        end
        else if (extended_sequences && ((data_byte & MASK_FC) == MASK_F8))
        begin
            info.need = 3'd4;
        end
        else if ((data_byte & MASK_F8) == MASK_F0)
        begin
            info.need = 3'd3;
        end
        else if ((data_byte & MASK_F0) == MASK_E0)
        begin
            info.need = 3'd2;
        end
        else if ((data_byte & MASK_E0) == MASK_C0)
        begin
            info.need = 3'd1;
        end
        else
        begin
            info.need = 3'd0;
        end
    end

endmodule

>>> hdl/utf8_validating_char_counter_core.sv
`timescale 1ns / 1ps
// A string's final byte is held in the input register, then its result word is registered.
// Throughput: one byte per cycle; the input stalls only while a finished
// result is held by a stalled output and the waiting byte is a final byte.
// Reset: rst_n is asynchronous and active low; it empties both registers and
// restores the modes to strict, stop at NUL, and no extended sequences.

module utf8_validating_char_counter_core
#(
    parameter longint unsigned MAX_BYTES = utf8vc_pkg::MAX_BYTES_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Byte input channel.
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      data_byte,
    input  logic                            last_byte,
    // Result output channel.
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [utf8vc_pkg::COUNT_W-1:0]  char_count,
    output logic [utf8vc_pkg::COUNT_W-1:0]  byte_count,
    output logic                            valid_res,
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic                            cfg_data
);
    import utf8vc_pkg::*;

    // Every counter and offset saturates at the smaller of MAX_BYTES and the
    // largest value the 16-bit result fields can carry.
    localparam logic [COUNT_W-1:0] SAT_CAP =
        (MAX_BYTES < 64'd65535) ? COUNT_W'(MAX_BYTES) : {COUNT_W{1'b1}};

    // Scan phase of the current string.
    typedef enum logic [1:0] {
        PH_SCAN,
        PH_NUL,
        PH_ERR,
        PH_ERR_NUL
    } phase_t;

    // Configuration registers.
    logic partial_on_error_reg, partial_on_error_next;
    logic stop_at_nul_reg, stop_at_nul_next;
    logic extended_sequences_reg, extended_sequences_next;

    // Input register: one byte word waiting to be scanned.
    logic       a_valid_reg, a_valid_next;
    logic [7:0] a_data_reg, a_data_next;
    logic       a_last_reg, a_last_next;

    // Per-string scan state.
    logic [2:0]         pend_reg, pend_next;
    logic [COUNT_W-1:0] chars_reg, chars_next;
    logic [COUNT_W-1:0] bpos_reg, bpos_next;
    logic [COUNT_W-1:0] seq_start_reg, seq_start_next;
    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] err_len_reg, err_len_next;

    // Result register.
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] char_count_reg, char_count_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic               valid_res_reg, valid_res_next;

    lead_info_t info;
    logic       advance;
    logic       in_take;

    // Intermediate values of one scan step.
    logic [2:0]         s_pend;
    logic [COUNT_W-1:0] s_chars;
    logic [COUNT_W-1:0] s_bpos;
    logic [COUNT_W-1:0] s_seq;
    phase_t             s_phase;
    logic [COUNT_W-1:0] s_err;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v >= SAT_CAP) ? SAT_CAP : v + COUNT_W'(1);
    endfunction

    utf8vc_lead_decode u_lead_decode
    (
        .data_byte          (a_data_reg),
        .extended_sequences (extended_sequences_reg),
        .info               (info)
    );

    // The held byte moves on unless it finishes a string while the result
    // register still holds a word the consumer has not taken.
    assign advance  = a_valid_reg && !(a_last_reg && out_valid_reg && out_stall);
    assign in_stall = a_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign cfg_ready = 1'b1;

    // Configuration writes; an index past the register list is ignored.
    always_comb
    begin
        partial_on_error_next   = partial_on_error_reg;
        stop_at_nul_next        = stop_at_nul_reg;
        extended_sequences_next = extended_sequences_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PARTIAL_ON_ERROR:   partial_on_error_next   = cfg_data;
                CFG_STOP_AT_NUL:        stop_at_nul_next        = cfg_data;
                CFG_EXTENDED_SEQUENCES: extended_sequences_next = cfg_data;
                default:                ;
            endcase
        end
    end

    // Input register load.
    always_comb
    begin
        a_valid_next = a_valid_reg;
        a_data_next  = a_data_reg;
        a_last_next  = a_last_reg;
        if (advance)
        begin
            a_valid_next = 1'b0;
        end
        if (in_take)
        begin
            a_valid_next = 1'b1;
            a_data_next  = data_byte;
            a_last_next  = last_byte;
        end
    end

    // One scan step for the held byte, followed by result formation when the
    // byte closes the string.
    always_comb
    begin
        s_pend  = pend_reg;
        s_chars = chars_reg;
        s_seq   = seq_start_reg;
        s_phase = phase_reg;
        s_err   = err_len_reg;

        if (phase_reg == PH_SCAN)
        begin
            if (pend_reg == 3'd0)
            begin
                // Lead position.
                if (info.is_nul)
                begin
                    if (stop_at_nul_reg)
                    begin
                        s_phase = PH_NUL;
                        s_err   = bpos_reg;
                    end
                    else
                    begin
                        s_chars = sat_inc(chars_reg);
                    end
                end
                else if (info.is_ascii)
                begin
                    s_chars = sat_inc(chars_reg);
                end
                else
                begin
                    s_seq = bpos_reg;
                    if (info.need == 3'd0)
                    begin
                        s_phase = PH_ERR;
                    end
                    else
                    begin
                        s_pend = info.need;
                    end
                end
            end
            else if (info.is_cont)
            begin
                s_pend = pend_reg - 3'd1;
                if (s_pend == 3'd0)
                begin
                    s_chars = sat_inc(chars_reg);
                end
            end
            else
            begin
                // A continuation byte was expected and something else came.
                s_pend  = 3'd0;
                s_phase = PH_ERR;
            end
        end

        // After an error, the first NUL seen gives the strict-mode offset.
        if ((s_phase == PH_ERR) && info.is_nul)
        begin
            s_phase = PH_ERR_NUL;
            s_err   = bpos_reg;
        end

        s_bpos = sat_inc(bpos_reg);

        pend_next       = pend_reg;
        chars_next      = chars_reg;
        bpos_next       = bpos_reg;
        seq_start_next  = seq_start_reg;
        phase_next      = phase_reg;
        err_len_next    = err_len_reg;

        out_valid_next  = out_valid_reg && out_stall;
        char_count_next = char_count_reg;
        byte_count_next = byte_count_reg;
        valid_res_next  = valid_res_reg;

        if (advance)
        begin
            if (a_last_reg)
            begin
                // A string that ends inside a sequence is an error at its lead.
                if ((s_phase == PH_SCAN) && (s_pend != 3'd0))
                begin
                    s_phase = PH_ERR;
                end
                out_valid_next = 1'b1;
                unique case (s_phase)
                    PH_SCAN:
                    begin
                        char_count_next = s_chars;
                        byte_count_next = s_bpos;
                        valid_res_next  = 1'b1;
                    end
                    PH_NUL:
                    begin
                        char_count_next = s_chars;
                        byte_count_next = s_err;
                        valid_res_next  = 1'b1;
                    end
                    PH_ERR, PH_ERR_NUL:
                    begin
                        valid_res_next = 1'b0;
                        if (partial_on_error_reg)
                        begin
                            char_count_next = s_chars;
                            byte_count_next = s_seq;
                        end
                        else
                        begin
                            char_count_next = '0;
                            byte_count_next = (s_phase == PH_ERR_NUL) ? s_err : s_bpos;
                        end
                    end
                    default:
                    begin
                        valid_res_next = 1'b0;
                    end
                endcase
                // The next byte starts a fresh string.
                pend_next      = 3'd0;
                chars_next     = '0;
                bpos_next      = '0;
                seq_start_next = '0;
                phase_next     = PH_SCAN;
                err_len_next   = '0;
            end
            else
            begin
                pend_next      = s_pend;
                chars_next     = s_chars;
                bpos_next      = s_bpos;
                seq_start_next = s_seq;
                phase_next     = s_phase;
                err_len_next   = s_err;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_on_error_reg   <= 1'b0;
            stop_at_nul_reg        <= 1'b1;
            extended_sequences_reg <= 1'b0;
            a_valid_reg            <= 1'b0;
            a_data_reg             <= '0;
            a_last_reg             <= 1'b0;
            pend_reg               <= 3'd0;
            chars_reg              <= '0;
            bpos_reg               <= '0;
            seq_start_reg          <= '0;
            phase_reg              <= PH_SCAN;
            err_len_reg            <= '0;
            out_valid_reg          <= 1'b0;
            char_count_reg         <= '0;
            byte_count_reg         <= '0;
            valid_res_reg          <= 1'b0;
        end
        else
        begin
            partial_on_error_reg   <= partial_on_error_next;
            stop_at_nul_reg        <= stop_at_nul_next;
            extended_sequences_reg <= extended_sequences_next;
            a_valid_reg            <= a_valid_next;
            a_data_reg             <= a_data_next;
            a_last_reg             <= a_last_next;
            pend_reg               <= pend_next;
            chars_reg              <= chars_next;
            bpos_reg               <= bpos_next;
            seq_start_reg          <= seq_start_next;
            phase_reg              <= phase_next;
            err_len_reg            <= err_len_next;
            out_valid_reg          <= out_valid_next;
            char_count_reg         <= char_count_next;
            byte_count_reg         <= byte_count_next;
            valid_res_reg          <= valid_res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign char_count = char_count_reg;
    assign byte_count = byte_count_reg;
    assign valid_res  = valid_res_reg;

endmodule

>>> hdl/utf8vc_checker.sv
`timescale 1ns / 1ps
`include "utf8_validating_char_counter_core_macros.svh"

module utf8vc_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic [7:0]                      data_byte,
    input logic                            last_byte,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [utf8vc_pkg::COUNT_W-1:0]  char_count,
    input logic [utf8vc_pkg::COUNT_W-1:0]  byte_count,
    input logic                            valid_res,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [1:0]                      cfg_index,
    input logic                            cfg_data
);
    import utf8vc_pkg::*;

    // All result fields side by side, and the acceptance of a final byte.
    logic [2*COUNT_W:0] out_word;
    logic               last_take;

    assign out_word  = {char_count, byte_count, valid_res};
    assign last_take = in_valid && !in_stall && last_byte;

    // A stalled result word stays offered.
    `UTF8VC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // A stalled result word keeps its fields.
    `UTF8VC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_word))

    // The input only backs up behind a result word that cannot leave.
    `UTF8VC_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

    // A new result word must trace back to an accepted final byte of a string.
    `UTF8VC_ASSERT_SAME(a_result_origin, clk, rst_n, $rose(out_valid), $past(last_take, 2))

endmodule

bind utf8_validating_char_counter_core utf8vc_checker u_utf8vc_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .char_count (char_count),
    .byte_count (byte_count),
    .valid_res  (valid_res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
);
